FILE: sv/brs_pkg.sv
// Package for the bitmap region scroller: word types, codes and sizes.
// Used by the csr, sequencer and top modules; depends on nothing.
`default_nettype none

package brs_pkg;

   // frame store geometry
   localparam int FB_BYTES       = 8192;
   localparam int MAX_LINE_BYTES = 64;
   localparam int ADDR_W         = $clog2(FB_BYTES);
   localparam int ROUND_ADD      = 7;
   localparam int BYTE_SHIFT     = 3;

   // reset values of the configuration registers
   localparam logic [6:0] LINE_BYTES_RESET = 7'd28;
   localparam logic [8:0] FRAME_ROWS_RESET = 9'd216;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 2'd1;
   localparam int CSR_DATA_W = 9;

   // item kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_SCROLL = 2'd2;

   // scroll directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_READ   = 2'd0;
   localparam logic [1:0] ST_DONE   = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [12:0] byte_address;
      logic [7:0]  write_data;
      logic [8:0]  region_x;
      logic [7:0]  region_y;
      logic [9:0]  region_width;
      logic [8:0]  region_height;
      logic [1:0]  direction;
   } req_word_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] status;
   } rsp_word_type;

   typedef struct packed {
      logic [6:0] line_bytes;
      logic [8:0] frame_rows;
   } geom_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

FILE: sv/brs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module brs_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 8192
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [DATA_W-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/brs_csr.sv
// Configuration registers of the scroller: row length in bytes and row count.
// Depends on brs_pkg.
`default_nettype none

module brs_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [brs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [brs_pkg::CSR_DATA_W-1:0]       csr_data,
   output brs_pkg::geom_type                   geom
);
   import brs_pkg::*;

   logic [6:0] line_bytes_ff, line_bytes_in;
   logic [8:0] frame_rows_ff, frame_rows_in;
   logic       wr_fire;

   assign csr_ready = 1'b1;
   assign wr_fire   = csr_valid & csr_ready;

   always_comb begin
      line_bytes_in = line_bytes_ff;
      frame_rows_in = frame_rows_ff;
      if (wr_fire) begin
         if (csr_index == CSR_LINE_BYTES) begin
            line_bytes_in = csr_data[6:0];
         end else if (csr_index == CSR_FRAME_ROWS) begin
            frame_rows_in = csr_data[8:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_bytes_ff <= LINE_BYTES_RESET;
         frame_rows_ff <= FRAME_ROWS_RESET;
      end else begin
         line_bytes_ff <= line_bytes_in;
         frame_rows_ff <= frame_rows_in;
      end
   end

   assign geom.line_bytes = line_bytes_ff;
   assign geom.frame_rows = frame_rows_ff;

endmodule

`default_nettype wire

FILE: sv/brs_seq.sv
// Sequencer of the scroller: clears the store after reset, serves byte reads
// and writes, and walks scroll regions byte by byte through the frame RAM.
// Depends on brs_pkg.
`default_nettype none

module brs_seq (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  brs_pkg::req_word_type  req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output brs_pkg::rsp_word_type  rsp_data,
   input  brs_pkg::geom_type      geom,
   output brs_pkg::mem_req_type   mem_req,
   input  wire [7:0]              mem_rd_data
);
   import brs_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RDATA = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_BASE  = 4'd4;
   localparam logic [3:0] S_ROW   = 4'd5;
   localparam logic [3:0] S_READ  = 4'd6;
   localparam logic [3:0] S_WRITE = 4'd7;
   localparam logic [3:0] S_ZERO  = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FB_BYTES - 1);
   localparam logic [16:0]       FB_LIMIT  = 17'(FB_BYTES);
   localparam logic [8:0]        LB_LIMIT  = 9'(MAX_LINE_BYTES);

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   req_word_type      item_ff, item_in;
   logic              addr_ok_ff, addr_ok_in;
   logic [1:0]        status_ff, status_in;
   logic [6:0]        xb_ff, xb_in;
   logic [6:0]        nb_ff, nb_in;
   logic [7:0]        row_start_ff, row_start_in;
   logic [8:0]        rows_left_ff, rows_left_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [6:0]        col_ff, col_in;
   logic              carry_ff, carry_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              out_free;
   logic              req_addr_ok;
   logic [6:0]        xb_w;
   logic [7:0]        nb_w;
   logic [15:0]       area_w;
   logic              reject_w;
   logic [9:0]        row_end_w;
   logic [14:0]       base_w;
   logic              is_vert;
   logic              is_left;
   logic              col_last;
   logic [6:0]        col_next;
   logic [ADDR_W-1:0] dst_addr;
   logic [ADDR_W-1:0] src_addr;
   logic [7:0]        shift_word;
   logic              shift_carry;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_addr_ok = (17'(req_data.byte_address) < FB_LIMIT);

   // region geometry: left edge and width rounded up to whole bytes
   assign xb_w   = 7'((10'(item_ff.region_x) + 10'(ROUND_ADD)) >> BYTE_SHIFT);
   assign nb_w   = 8'((11'(item_ff.region_width) + 11'(ROUND_ADD)) >> BYTE_SHIFT);
   assign area_w = 16'(geom.line_bytes) * 16'(geom.frame_rows);
   assign row_end_w = 10'(item_ff.region_y) + 10'(item_ff.region_height);

   assign reject_w = (geom.line_bytes == 7'd0)
                   || (9'(geom.line_bytes) > LB_LIMIT)
                   || (17'(area_w) > FB_LIMIT)
                   || (item_ff.region_height == 9'd0)
                   || (nb_w == 8'd0)
                   || ((9'(xb_w) + 9'(nb_w)) > 9'(geom.line_bytes))
                   || (row_end_w > 10'(geom.frame_rows));

   assign base_w = 15'(row_start_ff) * 15'(geom.line_bytes) + 15'(xb_ff);

   assign is_vert  = (item_ff.direction == DIR_UP) || (item_ff.direction == DIR_DOWN);
   assign is_left  = (item_ff.direction == DIR_LEFT);
   assign col_last = is_left ? (col_ff == 7'd0) : (col_ff == 7'(nb_ff - 7'd1));
   assign col_next = is_left ? 7'(col_ff - 7'd1) : 7'(col_ff + 7'd1);

   assign dst_addr = ADDR_W'(row_base_ff + ADDR_W'(col_ff));

   always_comb begin
      unique case (item_ff.direction)
         DIR_UP:   src_addr = ADDR_W'(dst_addr + ADDR_W'(geom.line_bytes));
         DIR_DOWN: src_addr = ADDR_W'(dst_addr - ADDR_W'(geom.line_bytes));
         default:  src_addr = dst_addr;
      endcase
   end

   always_comb begin
      unique case (item_ff.direction)
         DIR_RIGHT: begin
            shift_word  = {carry_ff, mem_rd_data[7:1]};
            shift_carry = mem_rd_data[0];
         end
         DIR_LEFT: begin
            shift_word  = {mem_rd_data[6:0], carry_ff};
            shift_carry = mem_rd_data[7];
         end
         default: begin
            shift_word  = mem_rd_data;
            shift_carry = carry_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      item_in      = item_ff;
      addr_ok_in   = addr_ok_ff;
      status_in    = status_ff;
      xb_in        = xb_ff;
      nb_in        = nb_ff;
      row_start_in = row_start_ff;
      rows_left_in = rows_left_ff;
      row_base_in  = row_base_ff;
      col_in       = col_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr_ff;
            mem_req.wr_data = 8'd0;
            clr_addr_in     = ADDR_W'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               item_in    = req_data;
               addr_ok_in = req_addr_ok;
               unique case (req_data.kind)
                  KIND_WRITE: begin
                     mem_req.wr_en   = req_addr_ok;
                     mem_req.wr_addr = ADDR_W'(req_data.byte_address);
                     mem_req.wr_data = req_data.write_data;
                  end
                  KIND_READ: begin
                     mem_req.rd_en   = req_addr_ok;
                     mem_req.rd_addr = ADDR_W'(req_data.byte_address);
                     state_in        = S_RDATA;
                  end
                  KIND_SCROLL: begin
                     state_in = S_CHECK;
                  end
                  default: begin
                     // drop unused kind
                  end
               endcase
            end
         end
         S_RDATA: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.read_data = addr_ok_ff ? mem_rd_data : 8'd0;
               rsp_data_in.status    = ST_READ;
               state_in              = S_IDLE;
            end
         end
         S_CHECK: begin
            xb_in        = xb_w;
            nb_in        = nb_w[6:0];
            rows_left_in = item_ff.region_height;
            row_start_in = (item_ff.direction == DIR_DOWN) ? 8'(row_end_w - 10'd1)
                                                            : item_ff.region_y;
            if (reject_w) begin
               status_in = ST_REJECT;
               state_in  = S_RESP;
            end else begin
               status_in = ST_DONE;
               state_in  = S_BASE;
            end
         end
         S_BASE: begin
            row_base_in = ADDR_W'(base_w);
            state_in    = S_ROW;
         end
         S_ROW: begin
            col_in   = is_left ? 7'(nb_ff - 7'd1) : 7'd0;
            carry_in = 1'b0;
            // last row of a vertical scroll is the vacated one: clear it
            state_in = (is_vert && rows_left_ff == 9'd1) ? S_ZERO : S_READ;
         end
         S_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = src_addr;
            state_in        = S_WRITE;
         end
         S_WRITE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = dst_addr;
            mem_req.wr_data = shift_word;
            carry_in        = shift_carry;
            if (col_last) begin
               if (rows_left_ff == 9'd1) begin
                  state_in = S_RESP;
               end else begin
                  rows_left_in = 9'(rows_left_ff - 9'd1);
                  row_base_in  = (item_ff.direction == DIR_DOWN)
                               ? ADDR_W'(row_base_ff - ADDR_W'(geom.line_bytes))
                               : ADDR_W'(row_base_ff + ADDR_W'(geom.line_bytes));
                  state_in     = S_ROW;
               end
            end else begin
               col_in   = col_next;
               state_in = S_READ;
            end
         end
         S_ZERO: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = dst_addr;
            mem_req.wr_data = 8'd0;
            col_in          = col_next;
            if (col_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.read_data = 8'd0;
               rsp_data_in.status    = status_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         carry_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         carry_ff     <= carry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      addr_ok_ff   <= addr_ok_in;
      status_ff    <= status_in;
      xb_ff        <= xb_in;
      nb_ff        <= nb_in;
      row_start_ff <= row_start_in;
      rows_left_ff <= rows_left_in;
      row_base_ff  <= row_base_in;
      col_ff       <= col_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: sv/bitmap_region_scroller.sv
// Bitmap region scroller: 1 bit per pixel frame buffer with one-pixel scrolls.
// Byte writes are taken one per cycle while idle; a read returns its byte via the
// RAM read register and the response register. A scroll checks the region, forms its
// base, then reads then writes each byte of each row (zeroing a vacated edge row)
// and responds; a rejected one responds after the check. After reset the RAM's 8192
// bytes clear one a cycle with req_stall high; config resets to 28 bytes, 216 rows.
`default_nettype none

module bitmap_region_scroller (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  brs_pkg::req_word_type             req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output brs_pkg::rsp_word_type             rsp_data,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [brs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [brs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import brs_pkg::*;

   geom_type    geom;
   mem_req_type mem_req;
   logic [7:0]  mem_rd_data;

   brs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   brs_ram #(
      .DATA_W (8),
      .DEPTH  (FB_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   brs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .geom        (geom),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire
